### hdl/decimal_q8_fixed_point_convert_macros.svh
// Assertion macros for the decimal / s7.8 converter.
// Used by the top level only; no other dependencies.
`ifndef DECIMAL_Q8_FIXED_POINT_CONVERT_MACROS_SVH
`define DECIMAL_Q8_FIXED_POINT_CONVERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DQ8_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DQ8_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dq8_pkg.sv
// Shared types and constants for the decimal / s7.8 converter.
// No dependencies.
package dq8_pkg;

    localparam int unsigned FRAC_BITS = 8;
    localparam logic [3:0]  MAX_DEC   = 4'd8;

    // command codes
    localparam logic CMD_TO_FIX = 1'b0;
    localparam logic CMD_TO_DEC = 1'b1;

    // input range guards for 0, 1 and 2 decimals
    localparam logic signed [15:0] OVER_HI0 = 16'sd127;
    localparam logic signed [15:0] OVER_LO0 = -16'sd128;
    localparam logic signed [15:0] OVER_HI1 = 16'sd1279;
    localparam logic signed [15:0] OVER_LO1 = -16'sd1280;
    localparam logic signed [15:0] OVER_HI2 = 16'sd12799;
    localparam logic signed [15:0] OVER_LO2 = -16'sd12800;

    // doubling window, multiply-by-5 window
    localparam logic signed [15:0] DBL_HI  = 16'sd16383;
    localparam logic signed [15:0] DBL_LO  = -16'sd16384;
    localparam logic signed [15:0] MUL_HI  = 16'sd6553;
    localparam logic signed [15:0] MUL_LO  = -16'sd6553;

    localparam logic signed [15:0] SAT_POS = 16'sd32767;
    localparam logic signed [15:0] SAT_NEG = -16'sd32768;

    // x / 5 == (x * 52429) >> 18, exact for 0 <= x <= 65535
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int unsigned DIV5_SHIFT = 18;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

endpackage

### hdl/dq8_datapath.sv
// Datapath: operand register, shift and decimal counters, one step unit.
// Depends on dq8_pkg.
module dq8_datapath (
    input  logic                   clk,
    input  dq8_pkg::ctrl_cmd_t     cmd,
    input  logic                   command,
    input  logic signed [15:0]     value,
    input  logic [3:0]             decimals,
    output dq8_pkg::dp_status_t    status,
    output logic signed [15:0]     result
);

    logic signed [15:0] v_reg, v_next;
    logic [3:0]         shifts_reg, shifts_next;
    logic [3:0]         dec_reg, dec_next;
    logic               dir_reg, dir_next;
    logic signed [15:0] result_reg, result_next;

    logic [3:0]         dec_in;
    logic               over;
    logic               dbl_ok, mul_ok;
    logic [16:0]        mag;
    logic [32:0]        prod;
    logic signed [15:0] quot;
    logic signed [15:0] div5;
    logic signed [15:0] dbl_sat;
    logic signed [15:0] final_val;

    always_comb
    begin
        dec_in = (decimals > dq8_pkg::MAX_DEC) ? dq8_pkg::MAX_DEC : decimals;
        case (dec_in)
            4'd0:    over = (value > dq8_pkg::OVER_HI0) || (value < dq8_pkg::OVER_LO0);
            4'd1:    over = (value > dq8_pkg::OVER_HI1) || (value < dq8_pkg::OVER_LO1);
            4'd2:    over = (value > dq8_pkg::OVER_HI2) || (value < dq8_pkg::OVER_LO2);
            default: over = 1'b0;
        endcase
    end

    // divide by 5, truncating toward zero
    always_comb
    begin
        mag  = v_reg[15] ? (17'd0 - {v_reg[15], v_reg}) : {1'b0, v_reg};
        prod = mag * {1'b0, dq8_pkg::DIV5_RECIP};
        quot = {1'b0, prod[32:dq8_pkg::DIV5_SHIFT]};
        div5 = v_reg[15] ? -quot : quot;
    end

    always_comb
    begin
        if (v_reg > dq8_pkg::DBL_HI)
            dbl_sat = dq8_pkg::SAT_POS;
        else if (v_reg < dq8_pkg::DBL_LO)
            dbl_sat = dq8_pkg::SAT_NEG;
        else
            dbl_sat = v_reg <<< 1;
    end

    assign dbl_ok = (shifts_reg != 4'd0) && (v_reg < dq8_pkg::DBL_HI)
                    && (v_reg > dq8_pkg::DBL_LO);
    assign mul_ok = (dec_reg != 4'd0) && (v_reg < dq8_pkg::MUL_HI)
                    && (v_reg > dq8_pkg::MUL_LO);

    always_comb
    begin
        if (dir_reg == dq8_pkg::CMD_TO_FIX)
            status.done = (shifts_reg == 4'd0) && (dec_reg == 4'd0);
        else
            status.done = !mul_ok && (shifts_reg == 4'd0);
    end

    // digits that did not fit saturate by sign
    always_comb
    begin
        if (dir_reg == dq8_pkg::CMD_TO_DEC && dec_reg != 4'd0)
            final_val = (v_reg > 16'sd0) ? dq8_pkg::SAT_POS : dq8_pkg::SAT_NEG;
        else
            final_val = v_reg;
    end

    always_comb
    begin
        v_next      = v_reg;
        shifts_next = shifts_reg;
        dec_next    = dec_reg;
        dir_next    = dir_reg;
        result_next = result_reg;
        if (cmd.load)
        begin
            dir_next    = command;
            v_next      = value;
            dec_next    = dec_in;
            shifts_next = 4'(dq8_pkg::FRAC_BITS) - dec_in;
            if (command == dq8_pkg::CMD_TO_FIX && over)
            begin
                v_next      = (value > 16'sd0) ? dq8_pkg::SAT_POS : dq8_pkg::SAT_NEG;
                dec_next    = 4'd0;
                shifts_next = 4'd0;
            end
            else if (command == dq8_pkg::CMD_TO_DEC
                     && (value == dq8_pkg::SAT_POS || value == dq8_pkg::SAT_NEG))
            begin
                // extremes pass through as sentinels
                dec_next    = 4'd0;
                shifts_next = 4'd0;
            end
        end
        else if (cmd.step)
        begin
            if (dir_reg == dq8_pkg::CMD_TO_FIX)
            begin
                if (dbl_ok)
                begin
                    v_next      = v_reg <<< 1;
                    shifts_next = shifts_reg - 4'd1;
                end
                else if (dec_reg != 4'd0)
                begin
                    v_next   = div5;
                    dec_next = dec_reg - 4'd1;
                end
                else if (shifts_reg != 4'd0)
                begin
                    v_next      = dbl_sat;
                    shifts_next = shifts_reg - 4'd1;
                end
            end
            else
            begin
                if (mul_ok)
                begin
                    v_next   = v_reg + (v_reg <<< 2);
                    dec_next = dec_reg - 4'd1;
                end
                else if (shifts_reg != 4'd0)
                begin
                    v_next      = v_reg >>> 1;
                    shifts_next = shifts_reg - 4'd1;
                end
            end
        end
        if (cmd.emit)
            result_next = final_val;
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        shifts_reg <= shifts_next;
        dec_reg    <= dec_next;
        dir_reg    <= dir_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

### hdl/dq8_ctrl.sv
// Controller: idle/run sequencer and output-valid register.
// Depends on dq8_pkg.
module dq8_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  dq8_pkg::dp_status_t  status,
    output dq8_pkg::ctrl_cmd_t   cmd
);

    dq8_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dq8_pkg::ST_IDLE:
                if (in_valid)
                    state_next = dq8_pkg::ST_RUN;
            dq8_pkg::ST_RUN:
                if (status.done && (!out_valid_reg || out_ready))
                    state_next = dq8_pkg::ST_IDLE;
            default:
                state_next = dq8_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            dq8_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            dq8_pkg::ST_RUN:
            begin
                cmd.step = !status.done;
                cmd.emit = status.done && (!out_valid_reg || out_ready);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq8_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/decimal_q8_fixed_point_convert.sv
// Top level: decimal scaled <-> s7.8 fixed-point temperature converter.
// Depends on dq8_pkg, dq8_ctrl, dq8_datapath and the macros header.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------
//  in      | in_valid / in_ready | command, value, decimals
//  out     | out_valid/out_ready | result
//
// One transfer in, one transfer out. The input is taken in the idle state,
// then the step unit does one doubling, halving, divide-by-5 or
// multiply-by-5 per cycle: 0 to 8 steps (the shifts and the divides or
// multiplies add up to at most eight), then the result is loaded into
// the output register.
// The step count follows the decimals and the operand's magnitude.
// Reset (rst_n, async, active low) clears the sequencer and out_valid.
// A finished result waits in the output register; the next input transfer
// is taken meanwhile, and only the final load waits on a stalled output.
module decimal_q8_fixed_point_convert (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [15:0] value,
    input  logic [3:0]         decimals,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] result
);

`include "decimal_q8_fixed_point_convert_macros.svh"

    dq8_pkg::ctrl_cmd_t  cmd;     // load / step / emit
    dq8_pkg::dp_status_t status;  // no step left

    dq8_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dq8_datapath u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .command  (command),
        .value    (value),
        .decimals (decimals),
        .status   (status),
        .result   (result)
    );

    // after an input transfer the block is busy with that item
    `DQ8_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while busy")

    // a new result only appears at the end of a conversion
    `DQ8_ASSERT_NOW(a_result_from_run, clk, rst_n, $rose(out_valid), !$past(in_ready), "result without conversion")

    // load, step and emit are mutually exclusive
    `DQ8_ASSERT_NOW(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.step, cmd.emit}), "conflicting datapath commands")

endmodule

### test/tb.sv
// Self-checking testbench for decimal_q8_fixed_point_convert (decimal <-> s7.8).
// Depends on dq8_pkg and the converter RTL; carries its own conversion predictor.
`timescale 1ns / 1ps

module tb;
    import dq8_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no transfer on either side
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off in the fill test
    localparam int DRAIN_PAUSE = 25;    // idle cycles after the last result, before the summary
    localparam int PHASE_ITEMS = 590;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic signed [15:0] value;
    logic [3:0]         decimals;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] result;

    // Converted values still owed by the block, oldest first.
    logic signed [15:0] pending_results[$];
    logic signed [15:0] oldest_result;

    int sender_idle_pct;
    int receiver_idle_pct;
    int error_count;
    int results_checked;
    int to_fixed_count;
    int to_decimal_count;
    int quiet_cycles;

    // Hold-off request: the test flips hold_req, the receiver owns the countdown.
    logic hold_req;
    logic hold_seen;
    int   hold_left;

    decimal_q8_fixed_point_convert uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .decimals  (decimals),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: decimal scaled value -> s7.8.
    // Doublings run while the value stays inside the doubling window; each
    // divide-by-5 truncates toward zero. Too few decimals and an operand
    // past the guard saturates at once. Once no divides are left, stalled
    // doublings saturate one at a time.
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] decimal_to_q8(int v, int digits);
        int  shifts;
        bit  over;
        shifts = int'(FRAC_BITS) - digits;
        over   = 1'b0;
        case (digits)
            0:       over = (v > OVER_HI0) || (v < OVER_LO0);
            1:       over = (v > OVER_HI1) || (v < OVER_LO1);
            2:       over = (v > OVER_HI2) || (v < OVER_LO2);
            default: over = 1'b0;
        endcase
        if (over)
            return (v > 0) ? SAT_POS : SAT_NEG;
        while (shifts > 0 || digits > 0)
        begin
            while (v < DBL_HI && v > DBL_LO && shifts > 0)
            begin
                shifts--;
                v = v * 2;
            end
            if (digits > 0)
            begin
                digits--;
                v = v / 5;
            end
            else
            begin
                while (shifts > 0)
                begin
                    shifts--;
                    v = v * 2;
                    if (v > SAT_POS) v = SAT_POS;
                    if (v < SAT_NEG) v = SAT_NEG;
                end
            end
        end
        return 16'(v);
    endfunction

    // s7.8 -> decimal scaled. Multiply by 5 while inside the window, halve
    // (floor) between. The two int16 extremes are sentinels and pass through;
    // if multiplies are still owed at the end the digits do not fit.
    function automatic logic signed [15:0] q8_to_decimal(int v, int digits);
        int shifts;
        shifts = int'(FRAC_BITS) - digits;
        if (v != SAT_NEG && v != SAT_POS)
        begin
            while (shifts > 0 || (digits > 0 && v < MUL_HI && v > MUL_LO))
            begin
                while (v < MUL_HI && v > MUL_LO && digits > 0)
                begin
                    digits--;
                    v = v * 5;
                end
                if (shifts > 0)
                begin
                    shifts--;
                    v = v >>> 1;
                end
            end
        end
        if (digits != 0)
            v = (v > 0) ? SAT_POS : SAT_NEG;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] convert_reading(logic cmd, logic signed [15:0] v,
                                                           logic [3:0] digits);
        int d;
        d = (digits > MAX_DEC) ? int'(MAX_DEC) : int'(digits);
        if (cmd == CMD_TO_DEC)
            return q8_to_decimal(int'(v), d);
        return decimal_to_q8(int'(v), d);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers one reading, holds it until the transfer, then records
    // the expected conversion. valid stays high into the next call, which
    // lowers it only when it decides to idle.
    // ------------------------------------------------------------------
    task automatic send_reading(input logic cmd, input logic signed [15:0] v,
                                input logic [3:0] digits);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= v;
        decimals <= digits;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(convert_reading(cmd, v, digits));
        if (cmd == CMD_TO_DEC) to_decimal_count++;
        else                   to_fixed_count++;
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge clk);
    endtask

    // Operand mix: full range, log-spread magnitudes, and values just around
    // the guard, window and saturation edges.
    function automatic logic signed [15:0] random_operand();
        logic signed [15:0] edges[14];
        int k;
        int mag;
        edges = '{OVER_HI0, OVER_LO0, OVER_HI1, OVER_LO1, OVER_HI2, OVER_LO2,
                  DBL_HI, DBL_LO, MUL_HI, MUL_LO, SAT_POS, SAT_NEG, 16'sd0, 16'sd256};
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1, 2:
            begin
                k   = $urandom_range(0, 15);
                mag = $urandom_range(0, (1 << k) - 1);
                return 16'($urandom_range(0, 1) ? -mag : mag);
            end
            default: return edges[$urandom_range(0, 13)] + 16'($urandom_range(0, 2)) - 16'sd1;
        endcase
    endfunction

    function automatic logic [3:0] random_decimals();
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(0, 8));
    endfunction

    // ------------------------------------------------------------------
    // Receiver and checker. Handshake values are sampled at the edge, before
    // the block's own updates land; out_ready is driven for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    $error("result: no conversion pending, actual %0d", result);
                    error_count++;
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (result !== oldest_result)
                    begin
                        $error("result: expected %0d, actual %0d", oldest_result, result);
                        error_count++;
                    end
                end
            end
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Watchdog: too long without a transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset();
        in_valid  <= 1'b0;
        out_ready <= 1'b0;
        command   <= CMD_TO_FIX;
        value     <= '0;
        decimals  <= '0;
        hold_req  <= 1'b0;
        hold_seen <= 1'b0;
        hold_left = 0;
        rst_n     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n     <= 1'b1;
        @(posedge clk);
    endtask

    // Decimal to s7.8: range guard on both sides for 0, 1 and 2 decimals,
    // full divide chains, decimals past 8.
    task automatic test_to_fixed_edges();
        send_reading(CMD_TO_FIX, 16'sd0,      4'd0);
        send_reading(CMD_TO_FIX, 16'sd127,    4'd0);
        send_reading(CMD_TO_FIX, 16'sd128,    4'd0);
        send_reading(CMD_TO_FIX, -16'sd128,   4'd0);
        send_reading(CMD_TO_FIX, -16'sd129,   4'd0);
        send_reading(CMD_TO_FIX, 16'sd1279,   4'd1);
        send_reading(CMD_TO_FIX, 16'sd1280,   4'd1);
        send_reading(CMD_TO_FIX, -16'sd1281,  4'd1);
        send_reading(CMD_TO_FIX, 16'sd12799,  4'd2);
        send_reading(CMD_TO_FIX, -16'sd12801, 4'd2);
        send_reading(CMD_TO_FIX, 16'sd32767,  4'd8);
        send_reading(CMD_TO_FIX, -16'sd32768, 4'd8);
        send_reading(CMD_TO_FIX, 16'sd12345,  4'd15);
        send_reading(CMD_TO_FIX, -16'sd1,     4'd3);
        wait_for_results();
    endtask

    // s7.8 to decimal: sentinels, digits that do not fit, floor halving of
    // negative values, decimals past 8.
    task automatic test_to_decimal_edges();
        send_reading(CMD_TO_DEC, 16'sd32767,  4'd2);
        send_reading(CMD_TO_DEC, -16'sd32768, 4'd4);
        send_reading(CMD_TO_DEC, 16'sd256,    4'd0);
        send_reading(CMD_TO_DEC, -16'sd257,   4'd1);
        send_reading(CMD_TO_DEC, 16'sd32766,  4'd8);
        send_reading(CMD_TO_DEC, -16'sd32767, 4'd3);
        send_reading(CMD_TO_DEC, 16'sd1,      4'd8);
        send_reading(CMD_TO_DEC, -16'sd1,     4'd9);
        send_reading(CMD_TO_DEC, 16'sd6400,   4'd2);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int send_idle, input int recv_idle);
        sender_idle_pct   = send_idle;
        receiver_idle_pct = recv_idle;
        repeat (PHASE_ITEMS)
            send_reading(logic'($urandom_range(0, 1)), random_operand(), random_decimals());
        wait_for_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the block backs up and drops in_ready; then the sender waits it out.
    task automatic test_output_hold();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_req <= ~hold_req;
        repeat (40)
            send_reading(logic'($urandom_range(0, 1)), random_operand(), random_decimals());
        wait_for_results();
    endtask

    initial
    begin
        error_count      = 0;
        results_checked  = 0;
        to_fixed_count   = 0;
        to_decimal_count = 0;
        sender_idle_pct   = 13;
        receiver_idle_pct = 85;

        test_reset();
        test_to_fixed_edges();
        test_to_decimal_edges();
        test_random_traffic(13, 85);
        test_random_traffic(85, 13);
        test_output_hold();
        test_random_traffic(0, 0);

        wait_for_results();
        repeat (DRAIN_PAUSE) @(posedge clk);

        $display("Covered %0d decimal-to-s7.8 and %0d s7.8-to-decimal conversions, %0d checked,",
                 to_fixed_count, to_decimal_count, results_checked);
        $display("under sender/receiver idling, back-to-back traffic and a long output hold-off.");
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/dq8_pkg.sv
hdl/dq8_datapath.sv
hdl/dq8_ctrl.sv
hdl/decimal_q8_fixed_point_convert.sv
test/tb.sv
